// ===== design/orc_pkg.sv =====
`default_nettype none

package orc_pkg;

	// Default geometry
	localparam int NUM_SETS_DEF  = 64;
	localparam int NUM_WAYS_DEF  = 8;
	localparam int ADDR_BITS_DEF = 32;
	localparam int TIME_BITS_DEF = 48;

	// Fixed field widths of the access and result beats
	localparam int ADDR_W     = 32;
	localparam int TIME_W     = 48;
	localparam int CNT_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	// Register reset values
	localparam logic [3:0] OFFSET_BITS_RST = 4'd6;
	localparam logic [2:0] INDEX_BITS_RST  = 3'd6;
	localparam logic [3:0] WAYS_IN_USE_RST = 4'd8;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OFFSET_BITS,
		CFG_INDEX_BITS,
		CFG_WAYS_IN_USE
	} cfg_reg_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic [TIME_W-1:0] next_use_time;
		logic              never_reused;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic              evicted;
		logic [ADDR_W-1:0] victim_address;
		logic [CNT_W-1:0]  miss_total;
		logic [CNT_W-1:0]  eviction_total;
	} rsp_t;

endpackage

`default_nettype wire

// ===== design/orc_ram.sv =====
`default_nettype none

module orc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/optimal_replacement_cache_sim.sv =====
// Access path: the set row is read at the accepting edge and looked up the next cycle.
// The row is then written back and the result registered in the write state.
// Accesses do not overlap, because of the read-modify-write of the set row with no
// forwarding; one access is in flight, and write-back waits while a result beat is stalled.
// Reset: registers, counters and controller clear at once; then a clearing pass
// empties every set row in turn while no access is taken.
`default_nettype none

module optimal_replacement_cache_sim
	import orc_pkg::*;
#(
	parameter int NUM_SETS  = NUM_SETS_DEF,
	parameter int NUM_WAYS  = NUM_WAYS_DEF,
	parameter int ADDR_BITS = ADDR_BITS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  req_valid,
	output logic                       req_stall,
	input  wire req_t                  req,
	output logic                       rsp_valid,
	input  wire logic                  rsp_stall,
	output rsp_t                       rsp
);

	localparam int KEY_W  = TIME_BITS + 1;
	localparam int ADR_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int MAX_IB = $clog2(NUM_SETS + 1) - 1;
	localparam int SET_W  = (MAX_IB > 0) ? MAX_IB : 1;
	localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int NW_W   = $clog2(NUM_WAYS + 1);
	localparam int TREE_N = 2 ** WAY_W;
	localparam int ROW_W  = NUM_WAYS * (1 + ADDR_BITS + KEY_W);

	// Configuration registers
	logic [3:0] offset_q;
	logic [2:0] index_q;
	logic [3:0] ways_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_BITS_RST;
			index_q  <= INDEX_BITS_RST;
			ways_q   <= WAYS_IN_USE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OFFSET_BITS: offset_q <= cfg_wdata[3:0];
				CFG_INDEX_BITS:  index_q  <= cfg_wdata[2:0];
				CFG_WAYS_IN_USE: ways_q   <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	// Effective split and associativity
	logic [3:0]      ib_eff;
	logic [NW_W-1:0] nw_eff;
	logic [4:0]      tag_shamt;

	always_comb begin
		ib_eff = ({1'b0, index_q} > 4'(MAX_IB)) ? 4'(MAX_IB) : {1'b0, index_q};
		if (ways_q == 4'd0) begin
			nw_eff = NW_W'(1);
		end else if (32'(ways_q) > 32'(NUM_WAYS)) begin
			nw_eff = NW_W'(NUM_WAYS);
		end else begin
			nw_eff = NW_W'(ways_q);
		end
		tag_shamt = {1'b0, offset_q} + {1'b0, ib_eff};
	end

	// Incoming address and key at storage widths
	logic [ADDR_BITS-1:0] addr_w;
	logic [TIME_BITS-1:0] time_w;

	for (genvar i = 0; i < ADDR_BITS; i++) begin : g_addr
		if (i < ADDR_W) begin : g_in
			assign addr_w[i] = req.address[i];
		end else begin : g_pad
			assign addr_w[i] = 1'b0;
		end
	end

	for (genvar i = 0; i < TIME_BITS; i++) begin : g_time
		if (i < TIME_W) begin : g_in
			assign time_w[i] = req.next_use_time[i];
		end else begin : g_pad
			assign time_w[i] = 1'b0;
		end
	end

	logic [SET_W-1:0]     req_set;
	logic [ADDR_BITS-1:0] req_tag;
	logic [KEY_W-1:0]     req_key;
	logic [ADDR_BITS-1:0] addr_sh;

	always_comb begin
		addr_sh = addr_w >> offset_q;
		req_set = addr_sh[SET_W-1:0] & ~({SET_W{1'b1}} << ib_eff);
		req_tag = addr_w >> tag_shamt;
		req_key = req.never_reused ? {1'b1, {TIME_BITS{1'b0}}} : {1'b0, time_w};
	end

	// Controller
	state_t state_q, state_d;
	logic   accept, advance, clr_last;
	logic   ram_we, ram_re;
	logic [ADR_W-1:0] clr_q;
	logic [ADR_W-1:0] ram_waddr;
	logic [ROW_W-1:0] ram_wdata, ram_rdata, row_new;
	logic             rsp_valid_q;
	logic [SET_W-1:0] set_q;

	assign clr_last = (clr_q == ADR_W'(NUM_SETS - 1));
	assign advance  = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		accept    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_stall = 1'b0;
				accept    = req_valid;
				if (req_valid) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				ram_waddr = ADR_W'(set_q);
				ram_wdata = row_new;
				if (advance) begin
					ram_we  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	assign ram_re = accept;

	// Clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR && !clr_last) begin
			clr_q <= clr_q + ADR_W'(1);
		end
	end

	// Set row memory: {keys, tags, valid} for every way
	orc_ram #(
		.WIDTH(ROW_W),
		.DEPTH(NUM_SETS)
	) u_rows (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ADR_W'(req_set)),
		.rdata (ram_rdata)
	);

	// Access held while its set is in flight
	logic [ADDR_BITS-1:0] tag_q;
	logic [KEY_W-1:0]     key_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			set_q <= req_set;
			tag_q <= req_tag;
			key_q <= req_key;
		end
	end

	// Unpack the row
	logic [NUM_WAYS-1:0]                rd_valid;
	logic [NUM_WAYS-1:0][ADDR_BITS-1:0] rd_tag;
	logic [NUM_WAYS-1:0][KEY_W-1:0]     rd_key;

	assign {rd_key, rd_tag, rd_valid} = ram_rdata;

	// Lookup: lowest hit, lowest empty way
	logic [NUM_WAYS-1:0] inuse, match;
	logic [WAY_W-1:0]    hit_way, empty_way;
	logic                any_hit, any_empty;

	always_comb begin
		hit_way   = '0;
		empty_way = '0;
		any_hit   = 1'b0;
		any_empty = 1'b0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			inuse[w] = (NW_W'(w) < nw_eff);
			match[w] = inuse[w] && rd_valid[w] && (rd_tag[w] == tag_q);
			if (match[w]) begin
				hit_way = WAY_W'(w);
				any_hit = 1'b1;
			end
			if (inuse[w] && !rd_valid[w]) begin
				empty_way = WAY_W'(w);
				any_empty = 1'b1;
			end
		end
	end

	// Furthest next use: compare tree, lower way wins a tie
	logic [KEY_W:0]   node_key [2*TREE_N];
	logic [WAY_W-1:0] node_idx [2*TREE_N];

	always_comb begin
		node_key[0] = '0;
		node_idx[0] = '0;
		for (int i = 0; i < TREE_N; i++) begin
			node_key[TREE_N+i] = '0;
			node_idx[TREE_N+i] = WAY_W'(i);
		end
		for (int w = 0; w < NUM_WAYS; w++) begin
			node_key[TREE_N+w] = {inuse[w], rd_key[w]};
		end
		for (int i = TREE_N - 1; i >= 1; i--) begin
			if (node_key[2*i+1] > node_key[2*i]) begin
				node_key[i] = node_key[2*i+1];
				node_idx[i] = node_idx[2*i+1];
			end else begin
				node_key[i] = node_key[2*i];
				node_idx[i] = node_idx[2*i];
			end
		end
	end

	// Lookup outcome
	logic             hit_q, evict_q;
	logic [WAY_W-1:0] slot_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_LOOK) begin
			hit_q   <= any_hit;
			evict_q <= !any_hit && !any_empty;
			if (any_hit) begin
				slot_q <= hit_way;
			end else if (any_empty) begin
				slot_q <= empty_way;
			end else begin
				slot_q <= node_idx[1];
			end
		end
	end

	// Updated row: chosen way gets the tag and key and turns valid
	logic [NUM_WAYS-1:0]                nx_valid;
	logic [NUM_WAYS-1:0][ADDR_BITS-1:0] nx_tag;
	logic [NUM_WAYS-1:0][KEY_W-1:0]     nx_key;

	always_comb begin
		nx_valid = rd_valid;
		nx_tag   = rd_tag;
		nx_key   = rd_key;
		nx_valid[slot_q] = 1'b1;
		nx_tag[slot_q]   = tag_q;
		nx_key[slot_q]   = key_q;
		row_new = {nx_key, nx_tag, nx_valid};
	end

	// Victim address from the current split
	logic [ADDR_BITS-1:0] set_ext, victim_full;
	logic [ADDR_W-1:0]    victim_out;

	always_comb begin
		set_ext     = ADDR_BITS'(set_q);
		victim_full = (rd_tag[slot_q] << tag_shamt) | (set_ext << offset_q);
	end

	for (genvar i = 0; i < ADDR_W; i++) begin : g_victim
		if (i < ADDR_BITS) begin : g_in
			assign victim_out[i] = evict_q & victim_full[i];
		end else begin : g_pad
			assign victim_out[i] = 1'b0;
		end
	end

	// Saturating counters
	logic [CNT_W-1:0] miss_q, evcnt_q, miss_d, evcnt_d;
	logic             done;

	assign done    = (state_q == ST_WRITE) && advance;
	assign miss_d  = (!hit_q && miss_q != '1) ? miss_q + CNT_W'(1) : miss_q;
	assign evcnt_d = (evict_q && evcnt_q != '1) ? evcnt_q + CNT_W'(1) : evcnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_q  <= '0;
			evcnt_q <= '0;
		end else if (done) begin
			miss_q  <= miss_d;
			evcnt_q <= evcnt_d;
		end
	end

	// Result register
	rsp_t rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q.hit            <= hit_q;
			rsp_q.evicted        <= evict_q;
			rsp_q.victim_address <= victim_out;
			rsp_q.miss_total     <= miss_d;
			rsp_q.eviction_total <= evcnt_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks
	a_rsp_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == ST_WRITE))
		else $error("result appeared without a row write-back");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> req_stall)
		else $error("access taken during clearing pass");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.hit && rsp.evicted))
		else $error("hit and eviction on one access");

	a_evict_le_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.eviction_total <= rsp.miss_total))
		else $error("more evictions than misses");

endmodule

`default_nettype wire

// ===== tb/optimal_replacement_cache_sim_tb.sv =====
module optimal_replacement_cache_sim_tb
	import orc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SET_BITS  = $clog2(NUM_SETS_DEF);
	localparam int DIR_ROWS  = 17;
	localparam int PHASES    = 6;
	localparam int PHASE_LEN = 72;

	// One directed access; want is only used where typed is set
	typedef struct packed {
		req_t acc;
		logic typed;
		rsp_t want;
	} dir_row_t;

	typedef struct packed {
		logic [3:0] offset_bits;
		logic [2:0] index_bits;
		logic [3:0] ways;
	} cache_cfg_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	req_t                  req_beat = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	rsp_t                  rsp_beat;

	// Mirror of the cache contents and registers
	logic [31:0]       line_tag [NUM_SETS_DEF][NUM_WAYS_DEF];
	logic [TIME_W:0]   line_key [NUM_SETS_DEF][NUM_WAYS_DEF];
	bit                line_ok [NUM_SETS_DEF][NUM_WAYS_DEF];
	logic [CNT_W-1:0]  misses = '0;
	logic [CNT_W-1:0]  evictions = '0;
	logic [3:0]        offset_bits_m = OFFSET_BITS_RST;
	logic [2:0]        index_bits_m = INDEX_BITS_RST;
	logic [3:0]        ways_m = WAYS_IN_USE_RST;

	rsp_t pending_results [$];
	int   fail_count = 0;
	int   tx_idle_pct = 0;
	int   rx_idle_pct = 0;
	bit   cur_typed = 1'b0;
	rsp_t cur_want = '0;
	logic [31:0] tag_base = '0;

	// Set 0 filled until the Belady victim is chosen; set 63 touched at both ends
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{'{32'h0000_0000, 48'h0, 1'b0}, 1'b1, '{1'b0, 1'b0, 32'h0, 32'd1, 32'd0}},
		'{'{32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0}, 1'b1,
			'{1'b0, 1'b0, 32'h0, 32'd2, 32'd0}},
		'{'{32'h0000_0000, 48'h0, 1'b1}, 1'b1, '{1'b1, 1'b0, 32'h0, 32'd2, 32'd0}},
		'{'{32'h0000_003F, 48'd5, 1'b0}, 1'b1, '{1'b1, 1'b0, 32'h0, 32'd2, 32'd0}},
		'{'{32'h0000_1000, 48'd10, 1'b0}, 1'b1, '{1'b0, 1'b0, 32'h0, 32'd3, 32'd0}},
		'{'{32'h0000_2000, 48'd90, 1'b0}, 1'b1, '{1'b0, 1'b0, 32'h0, 32'd4, 32'd0}},
		'{'{32'h0000_3000, 48'd30, 1'b0}, 1'b1, '{1'b0, 1'b0, 32'h0, 32'd5, 32'd0}},
		'{'{32'h0000_4000, 48'd90, 1'b0}, 1'b1, '{1'b0, 1'b0, 32'h0, 32'd6, 32'd0}},
		'{'{32'h0000_5000, 48'd20, 1'b0}, 1'b1, '{1'b0, 1'b0, 32'h0, 32'd7, 32'd0}},
		'{'{32'h0000_6000, 48'd40, 1'b0}, 1'b1, '{1'b0, 1'b0, 32'h0, 32'd8, 32'd0}},
		'{'{32'h0000_7000, 48'd50, 1'b0}, 1'b1, '{1'b0, 1'b0, 32'h0, 32'd9, 32'd0}},
		'{'{32'h0000_8000, 48'd1, 1'b0}, 1'b0, '0},
		'{'{32'h0000_9000, 48'd0, 1'b1}, 1'b0, '0},
		'{'{32'h0000_A000, 48'd0, 1'b0}, 1'b0, '0},
		'{'{32'h0000_2000, 48'd7, 1'b0}, 1'b0, '0},
		'{'{32'h0000_0FC0, 48'd3, 1'b0}, 1'b0, '0},
		'{'{32'hFFFF_FFC0, 48'd3, 1'b0}, 1'b0, '0}
	};

	// Phase 0 runs on reset values; the rest are written before their phase
	cache_cfg_t phase_cfg [PHASES] = '{
		'{4'd6, 3'd6, 4'd8},
		'{4'd0, 3'd0, 4'd1},
		'{4'd12, 3'd7, 4'd0},
		'{4'd15, 3'd3, 4'd15},
		'{4'd3, 3'd2, 4'd4},
		'{4'd12, 3'd6, 4'd8}
	};

	optimal_replacement_cache_sim u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req_beat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp_beat)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Set index width is capped at what the set count allows
	function automatic int unsigned eff_set_bits();
		return (index_bits_m > SET_BITS) ? SET_BITS : index_bits_m;
	endfunction

	// Zero ways acts as one, too many as all
	function automatic int unsigned eff_way_count();
		if (ways_m == 0)
			return 1;
		return (ways_m > NUM_WAYS_DEF) ? NUM_WAYS_DEF : ways_m;
	endfunction

	// Lookup, fill or furthest-next-use eviction; updates the mirror
	function automatic rsp_t predict_access(req_t a);
		rsp_t            r;
		logic [TIME_W:0] key;
		logic [31:0]     tag;
		logic [31:0]     set;
		logic [63:0]     vic;
		int unsigned     ob, ib, nw, w, slot;
		bit              found;
		ob = offset_bits_m;
		ib = eff_set_bits();
		nw = eff_way_count();
		key = a.never_reused ? ((TIME_W+1)'(1) << TIME_W) : {1'b0, a.next_use_time};
		set = (a.address >> ob) & ((32'h1 << ib) - 32'h1);
		tag = a.address >> (ob + ib);
		r = '0;
		found = 1'b0;
		for (w = 0; w < nw; w++) begin
			if (!found && line_ok[set][w] && line_tag[set][w] == tag) begin
				line_key[set][w] = key;
				found = 1'b1;
			end
		end
		r.hit = found;
		if (!found) begin
			if (misses != '1)
				misses++;
			slot = nw;
			for (w = 0; w < nw; w++) begin
				if (!line_ok[set][w] && slot == nw)
					slot = w;
			end
			// full set: strictly larger key wins, so ties stay on the lowest way
			if (slot == nw) begin
				slot = 0;
				for (w = 1; w < nw; w++) begin
					if (line_key[set][w] > line_key[set][slot])
						slot = w;
				end
				r.evicted = 1'b1;
				if (evictions != '1)
					evictions++;
				vic = (64'(line_tag[set][slot]) << (ob + ib)) | (64'(set) << ob);
				r.victim_address = vic[31:0];
			end
			line_tag[set][slot] = tag;
			line_key[set][slot] = key;
			line_ok[set][slot] = 1'b1;
		end
		r.miss_total = misses;
		r.eviction_total = evictions;
		return r;
	endfunction

	// Mostly a few tags over a few sets so sets fill and evict; some pure noise
	function automatic req_t random_access();
		req_t        a;
		logic [31:0] tag, set, off;
		int unsigned ob, ib, roll;
		ob = offset_bits_m;
		ib = eff_set_bits();
		roll = $urandom_range(99);
		if (roll < 15) begin
			a.address = $urandom;
		end else begin
			tag = tag_base + $urandom_range(eff_way_count() + 2);
			set = $urandom_range(((1 << ib) < 4) ? (1 << ib) - 1 : 3);
			off = $urandom & ((32'h1 << ob) - 32'h1);
			a.address = (tag << (ob + ib)) | (set << ob) | off;
		end
		roll = $urandom_range(99);
		a.next_use_time = TIME_W'({$urandom, $urandom});
		if (roll < 60)
			a.next_use_time = TIME_W'($urandom_range(15));
		a.never_reused = (roll >= 85);
		return a;
	endfunction

	task automatic check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0h, got %0h", name, want_v, got_v);
			fail_count++;
		end
	endtask

	// Scoreboard: check result beats, predict accepted accesses, track register writes
	always @(posedge clk) begin : scoreboard
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_results.size() == 0) begin
					$error("result beat with no access outstanding");
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					check_field("hit", want.hit, rsp_beat.hit);
					check_field("evicted", want.evicted, rsp_beat.evicted);
					check_field("victim_address", want.victim_address,
						rsp_beat.victim_address);
					check_field("miss_total", want.miss_total, rsp_beat.miss_total);
					check_field("eviction_total", want.eviction_total,
						rsp_beat.eviction_total);
				end
			end
			if (req_valid && !req_stall) begin
				want = predict_access(req_beat);
				if (cur_typed)
					want = cur_want;
				pending_results.push_back(want);
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_OFFSET_BITS: offset_bits_m = cfg_wdata;
					CFG_INDEX_BITS:  index_bits_m = cfg_wdata[2:0];
					CFG_WAYS_IN_USE: ways_m = cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	// Receiver back-pressure
	always @(negedge clk)
		rsp_stall <= ($urandom_range(99) < rx_idle_pct);

	// Present one access beat and hold it until taken
	task automatic send_access(req_t a, bit typed, rsp_t want);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		cur_typed = typed;
		cur_want = want;
		req_valid <= 1'b1;
		req_beat <= a;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Stop sending and let every outstanding result come back
	task automatic drain_results();
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
	endtask

	task automatic set_idle_mode(int mode);
		case (mode)
			0: begin
				tx_idle_pct = 8;
				rx_idle_pct = 78;
			end
			1: begin
				tx_idle_pct = 78;
				rx_idle_pct = 8;
			end
			default: begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
		endcase
	endtask

	initial begin : stimulus
		int p, i;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		set_idle_mode(0);

		// directed accesses on the reset configuration
		for (i = 0; i < DIR_ROWS; i++)
			send_access(dir_rows[i].acc, dir_rows[i].typed, dir_rows[i].want);
		drain_results();

		// random phases, each under its own register setting
		for (p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				write_reg(CFG_OFFSET_BITS, phase_cfg[p].offset_bits);
				write_reg(CFG_INDEX_BITS, CFG_DATA_W'(phase_cfg[p].index_bits));
				write_reg(CFG_WAYS_IN_USE, phase_cfg[p].ways);
				cfg_we <= 1'b0;
				@(negedge clk);
			end
			set_idle_mode(p / 2);
			tag_base = $urandom;
			for (i = 0; i < PHASE_LEN; i++)
				send_access(random_access(), 1'b0, '0);
			drain_results();
		end

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
